FILE: hw/rtl/ovle_pkg.sv
package ovle_pkg;

	localparam int DATA_W         = 32;
	localparam int COUNT_OUT_W    = 5;
	localparam int LIST_DEPTH_DEF = 16;

	typedef enum logic [3:0] {
		OP_PUSH_FRONT    = 4'd0,
		OP_PUSH_BACK     = 4'd1,
		OP_POP_FRONT     = 4'd2,
		OP_POP_BACK      = 4'd3,
		OP_INSERT_AFTER  = 4'd4,
		OP_INSERT_BEFORE = 4'd5,
		OP_REMOVE_AFTER  = 4'd6,
		OP_REMOVE_BEFORE = 4'd7,
		OP_REMOVE_MATCH  = 4'd8,
		OP_CONTAINS      = 4'd9,
		OP_CLEAR         = 4'd10
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE      = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_MATCH,
		S_APPLY
	} state_t;

	// broadcast to every cell
	typedef struct packed {
		logic cmp;   // register key compare
		logic ins;   // open a slot at the insert point
		logic rem;   // close the slot at the remove point
	} cell_ctl_t;

endpackage

FILE: hw/rtl/ovle_cell.sv
module ovle_cell
	import ovle_pkg::*;
(
	input  logic              clk,
	input  cell_ctl_t         ctl,
	input  logic              ge,
	input  logic              eq,
	input  logic [DATA_W-1:0] key,
	input  logic [DATA_W-1:0] value,
	input  logic [DATA_W-1:0] left_data,
	input  logic [DATA_W-1:0] right_data,
	output logic [DATA_W-1:0] data,
	output logic              match
);

	logic [DATA_W-1:0] data_q;
	logic              match_q;

	always_ff @(posedge clk) begin
		if (ctl.cmp) begin
			match_q <= (data_q == key);
		end
		if (ctl.ins && eq) begin
			data_q <= value;
		end else if (ctl.ins && ge) begin
			data_q <= left_data;
		end else if (ctl.rem && ge) begin
			data_q <= right_data;
		end
	end

	assign data  = data_q;
	assign match = match_q;

endmodule

FILE: hw/rtl/ovle_ctrl.sv
module ovle_ctrl
	import ovle_pkg::*;
#(
	parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [3:0]             operation,
	input  logic [DATA_W-1:0]      key,
	input  logic [DATA_W-1:0]      value,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [1:0]             status,
	output logic [COUNT_OUT_W-1:0] entry_count,
	input  logic [LIST_DEPTH-1:0]  match,
	output cell_ctl_t              ctl,
	output logic [LIST_DEPTH-1:0]  ge,
	output logic [LIST_DEPTH-1:0]  eq,
	output logic [DATA_W-1:0]      key_q,
	output logic [DATA_W-1:0]      value_q
);

	localparam int CNT_W = $clog2(LIST_DEPTH + 1);

	state_t                 state_q, state_nxt;
	op_t                    op_q;
	logic [CNT_W-1:0]       count_q, count_nxt;
	logic                   out_valid_q;
	status_t                status_q, status_nxt;
	logic [COUNT_OUT_W-1:0] entry_count_q;

	logic                  apply_go, accept;
	logic [LIST_DEPTH-1:0] occ, hit, pre;
	logic                  found, empty, full;
	logic                  do_ins, do_rem, do_clr;

	// occupied cells and first-match prefix
	for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_pos
		assign occ[i] = (CNT_W'(i) < count_q);
		assign pre[i] = |hit[i:0];
	end

	assign hit   = match & occ;
	assign found = pre[LIST_DEPTH-1];
	assign empty = (count_q == '0);
	assign full  = (count_q == CNT_W'(LIST_DEPTH));

	assign apply_go = (state_q == S_APPLY) && (!out_valid_q || !out_stall);
	assign accept   = in_valid && !in_stall;

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_nxt = S_MATCH;
			end
			S_MATCH: begin
				state_nxt = S_APPLY;
			end
			S_APPLY: begin
				if (apply_go) state_nxt = in_valid ? S_MATCH : S_IDLE;
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	// outputs and command decode
	always_comb begin
		in_stall   = !((state_q == S_IDLE) || apply_go);
		ge         = '0;
		do_ins     = 1'b0;
		do_rem     = 1'b0;
		do_clr     = 1'b0;
		status_nxt = ST_NOT_FOUND;
		unique case (op_q)
			OP_PUSH_FRONT, OP_PUSH_BACK: begin
				ge = (op_q == OP_PUSH_FRONT) ? '1 : ~occ;
				if (full) begin
					status_nxt = ST_FULL;
				end else begin
					do_ins     = 1'b1;
					status_nxt = ST_DONE;
				end
			end
			OP_POP_FRONT, OP_POP_BACK: begin
				ge = (op_q == OP_POP_FRONT) ? '1 : ~{1'b0, occ[LIST_DEPTH-1:1]};
				if (!empty) begin
					do_rem     = 1'b1;
					status_nxt = ST_DONE;
				end
			end
			OP_INSERT_AFTER, OP_INSERT_BEFORE: begin
				if (empty) begin
					ge = '1;
				end else if (op_q == OP_INSERT_AFTER) begin
					ge = {pre[LIST_DEPTH-2:0], 1'b0};
				end else begin
					ge = pre;
				end
				if (full) begin
					status_nxt = ST_FULL;
				end else if (empty || found) begin
					do_ins     = 1'b1;
					status_nxt = ST_DONE;
				end
			end
			OP_REMOVE_AFTER: begin
				ge = {pre[LIST_DEPTH-2:0], 1'b0};
				if (|(ge & occ)) begin
					do_rem     = 1'b1;
					status_nxt = ST_DONE;
				end
			end
			OP_REMOVE_BEFORE: begin
				ge = {found, pre[LIST_DEPTH-1:1]};
				if (found && !hit[0]) begin
					do_rem     = 1'b1;
					status_nxt = ST_DONE;
				end
			end
			OP_REMOVE_MATCH: begin
				ge = pre;
				if (found) begin
					do_rem     = 1'b1;
					status_nxt = ST_DONE;
				end
			end
			OP_CONTAINS: begin
				if (found) status_nxt = ST_DONE;
			end
			OP_CLEAR: begin
				do_clr     = 1'b1;
				status_nxt = ST_DONE;
			end
			default: ;
		endcase
		eq      = ge & ~{ge[LIST_DEPTH-2:0], 1'b0};
		ctl.cmp = (state_q == S_MATCH);
		ctl.ins = apply_go && do_ins;
		ctl.rem = apply_go && do_rem;
	end

	always_comb begin
		count_nxt = count_q;
		if (do_clr) begin
			count_nxt = '0;
		end else if (do_ins) begin
			count_nxt = count_q + CNT_W'(1);
		end else if (do_rem) begin
			count_nxt = count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (apply_go) begin
				count_q     <= count_nxt;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// request and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= op_t'(operation);
			key_q   <= key;
			value_q <= value;
		end
		if (apply_go) begin
			status_q      <= status_nxt;
			entry_count_q <= COUNT_OUT_W'(count_nxt);
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign entry_count = entry_count_q;

endmodule

FILE: hw/rtl/ordered_value_list_engine.sv
// Ordered list of up to LIST_DEPTH signed 32-bit values, front at cell 0, one
// command per request. Each cell stores one entry and compares it with the key;
// inserts shift entries one cell toward the back, removes one cell toward the
// front, all cells at once. A request passes through a compare state, which
// registers the key compare in every cell, and an apply state, which finds the
// first match, updates the cells and loads the result register. A new request
// is taken in the cycle its predecessor's result is loaded, and not before, so
// requests do not overlap; a stalled result holds the block only while the
// result register is still full. Entry contents are not reset; only the count is.
module ordered_value_list_engine
	import ovle_pkg::*;
#(
	parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [3:0]             operation,
	input  logic signed [DATA_W-1:0] key,
	input  logic signed [DATA_W-1:0] value,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [1:0]             status,
	output logic [COUNT_OUT_W-1:0] entry_count
);

	cell_ctl_t             ctl;
	logic [LIST_DEPTH-1:0] ge, eq, match;
	logic [DATA_W-1:0]     key_q, value_q;
	logic [DATA_W-1:0]     cell_data [LIST_DEPTH];

	ovle_ctrl #(
		.LIST_DEPTH(LIST_DEPTH)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.operation  (operation),
		.key        (key),
		.value      (value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.entry_count(entry_count),
		.match      (match),
		.ctl        (ctl),
		.ge         (ge),
		.eq         (eq),
		.key_q      (key_q),
		.value_q    (value_q)
	);

	for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
		logic [DATA_W-1:0] left_d, right_d;
		if (i == 0) begin : g_first
			assign left_d = value_q;
		end else begin : g_mid_l
			assign left_d = cell_data[i-1];
		end
		if (i == LIST_DEPTH - 1) begin : g_last
			assign right_d = cell_data[i];
		end else begin : g_mid_r
			assign right_d = cell_data[i+1];
		end
		ovle_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.ge        (ge[i]),
			.eq        (eq[i]),
			.key       (key_q),
			.value     (value_q),
			.left_data (left_d),
			.right_data(right_d),
			.data      (cell_data[i]),
			.match     (match[i])
		);
	end

endmodule

FILE: hw/rtl/ovle_checker.sv
module ovle_checker
	import ovle_pkg::*;
#(
	parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_stall,
	input logic                   out_valid,
	input logic                   out_stall,
	input logic [1:0]             status,
	input logic [COUNT_OUT_W-1:0] entry_count
);

	// compare cycle follows every accepted request
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request accepted during compare cycle");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_DONE || status == ST_NOT_FOUND || status == ST_FULL))
		else $error("undefined status code");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_FULL |-> entry_count == COUNT_OUT_W'(LIST_DEPTH))
		else $error("full refusal with list not full");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(entry_count))
		else $error("stalled result changed");

endmodule

bind ordered_value_list_engine ovle_checker #(
	.LIST_DEPTH(LIST_DEPTH)
) u_ovle_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.status     (status),
	.entry_count(entry_count)
);

FILE: test/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import ovle_pkg::*;

	localparam int DEPTH        = LIST_DEPTH_DEF;
	localparam int RANDOM_ITEMS = 600;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int SETTLE       = 8;
	localparam int OP_CODE_MAX  = (1 << $bits(op_t)) - 1;

	typedef logic signed [DATA_W-1:0] word_t;

	typedef struct packed {
		status_t                status;
		logic [COUNT_OUT_W-1:0] count;
	} list_reply_t;

	typedef enum {MIX_GROW, MIX_SHRINK, MIX_EVEN} list_mix_t;
	typedef enum {STALL_NONE, STALL_RANDOM, STALL_RUNS} stall_style_t;

	localparam op_t GROW_OPS[4] = '{OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT_AFTER,
		OP_INSERT_BEFORE};
	localparam op_t SHRINK_OPS[5] = '{OP_POP_FRONT, OP_POP_BACK, OP_REMOVE_AFTER,
		OP_REMOVE_BEFORE, OP_REMOVE_MATCH};

	localparam word_t WORD_MAX = 32'sh7fff_ffff;
	localparam word_t WORD_MIN = 32'sh8000_0000;

	class list_scoreboard;
		word_t       held[DEPTH];
		int          held_count;
		list_reply_t pending_replies[$];
		int          errors;
		int          requests;
		int          replies;
		int          refused;
		int          idle_cmds;
		int          peak;

		function new();
			held_count = 0;
			errors     = 0;
			requests   = 0;
			replies    = 0;
			refused    = 0;
			idle_cmds  = 0;
			peak       = 0;
		endfunction

		function int pending();
			return pending_replies.size();
		endfunction

		function int find_first(word_t k);
			for (int i = 0; i < held_count; i++)
				if (held[i] == k)
					return i;
			return held_count;
		endfunction

		function void open_slot(int pos, word_t v);
			for (int i = held_count; i > pos; i--)
				held[i] = held[i - 1];
			held[pos] = v;
			held_count++;
		endfunction

		function void close_slot(int pos);
			for (int i = pos; i + 1 < held_count; i++)
				held[i] = held[i + 1];
			held_count--;
		endfunction

		// prefer keys that are in the list so searches mostly hit
		function word_t pick_key();
			int r;
			r = $urandom_range(9, 0);
			if (held_count > 0 && r < 7)
				return held[$urandom_range(held_count - 1, 0)];
			if (r < 8)
				return word_t'($urandom_range(2, 0)) - 1;
			return word_t'($urandom);
		endfunction

		// duplicates and small values make first-match ordering matter
		function word_t pick_value();
			int r;
			r = $urandom_range(3, 0);
			if (r == 0)
				return word_t'($urandom_range(2, 0)) - 1;
			if (r == 1 && held_count > 0)
				return held[$urandom_range(held_count - 1, 0)];
			return word_t'($urandom);
		endfunction

		function void note_request(logic [3:0] op, word_t k, word_t v);
			int          m;
			bit          full;
			status_t     st;
			list_reply_t r;
			full = (held_count >= DEPTH);
			m    = find_first(k);
			st   = ST_NOT_FOUND;
			case (op)
			OP_PUSH_FRONT, OP_PUSH_BACK: begin
				if (full) begin
					st = ST_FULL;
				end else begin
					open_slot((op == OP_PUSH_FRONT) ? 0 : held_count, v);
					st = ST_DONE;
				end
			end
			OP_POP_FRONT, OP_POP_BACK: begin
				if (held_count != 0) begin
					close_slot((op == OP_POP_FRONT) ? 0 : held_count - 1);
					st = ST_DONE;
				end
			end
			OP_INSERT_AFTER, OP_INSERT_BEFORE: begin
				if (full) begin
					st = ST_FULL;
				end else if (held_count == 0) begin
					open_slot(0, v);
					st = ST_DONE;
				end else if (m < held_count) begin
					open_slot((op == OP_INSERT_AFTER) ? m + 1 : m, v);
					st = ST_DONE;
				end
			end
			OP_REMOVE_AFTER: begin
				if (m + 1 < held_count) begin
					close_slot(m + 1);
					st = ST_DONE;
				end
			end
			OP_REMOVE_BEFORE: begin
				if (m < held_count && m != 0) begin
					close_slot(m - 1);
					st = ST_DONE;
				end
			end
			OP_REMOVE_MATCH: begin
				if (m < held_count) begin
					close_slot(m);
					st = ST_DONE;
				end
			end
			OP_CONTAINS: begin
				if (m < held_count)
					st = ST_DONE;
			end
			OP_CLEAR: begin
				held_count = 0;
				st = ST_DONE;
			end
			default: begin
			end
			endcase
			requests++;
			if (st == ST_FULL)
				refused++;
			if (st == ST_NOT_FOUND)
				idle_cmds++;
			if (held_count > peak)
				peak = held_count;
			r.status = st;
			r.count  = COUNT_OUT_W'(held_count);
			pending_replies.push_back(r);
		endfunction

		task report_mismatch(string msg);
			$display("[%0t] MISMATCH: %s", $time, msg);
			errors++;
		endtask

		task check_result(logic [1:0] got_status, logic [COUNT_OUT_W-1:0] got_count);
			list_reply_t want;
			replies++;
			if (pending_replies.size() == 0) begin
				report_mismatch($sformatf("reply status %0d count %0d with no request waiting",
					got_status, got_count));
			end else begin
				want = pending_replies.pop_front();
				if (got_status !== want.status)
					report_mismatch($sformatf("reply %0d status %0d, predicted %0d",
						replies, got_status, want.status));
				if (got_count !== want.count)
					report_mismatch($sformatf("reply %0d entry_count %0d, predicted %0d",
						replies, got_count, want.count));
			end
		endtask
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_stall;
	logic [3:0]             operation;
	word_t                  key;
	word_t                  value;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic [1:0]             status;
	logic [COUNT_OUT_W-1:0] entry_count;

	list_scoreboard tracker = new();
	int             cycle_count;
	stall_style_t   stall_style = STALL_NONE;
	int             stall_left = 0;
	int             stall_run = 0;

	ordered_value_list_engine uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.operation  (operation),
		.key        (key),
		.value      (value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.entry_count(entry_count)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			tracker.note_request(operation, key, value);
		if (arst_n && out_valid && !out_stall)
			tracker.check_result(status, entry_count);
	end

	// receiver: switch between no stall, scattered stalls and long stall runs
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_style = stall_style_t'($urandom_range(STALL_RUNS, STALL_NONE));
			stall_left  = $urandom_range(96, 16);
		end
		stall_left--;
		case (stall_style)
		STALL_NONE: begin
			out_stall <= 1'b0;
		end
		STALL_RANDOM: begin
			out_stall <= ($urandom_range(2, 0) == 0);
		end
		default: begin
			if (stall_run == 0) begin
				out_stall <= !out_stall;
				stall_run = $urandom_range(12, 1);
			end else begin
				stall_run--;
			end
		end
		endcase
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d replies outstanding", cycle_count,
			tracker.pending());
		$display("ordered_value_list_engine verification failed");
		$finish;
	end

	task automatic send_request(input logic [3:0] op, input word_t k, input word_t v);
		@(negedge clk);
		in_valid  = 1'b1;
		operation = op;
		key       = k;
		value     = v;
		do
			@(posedge clk);
		while (in_stall);
	endtask

	task automatic idle_cycles(input int n);
		repeat (n) begin
			@(negedge clk);
			in_valid = 1'b0;
		end
	endtask

	// hold off new requests until every reply is back
	task automatic wait_for_replies();
		@(negedge clk);
		in_valid = 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
	endtask

	function automatic logic [3:0] choose_operation(list_mix_t mix);
		int r;
		int grow_share;
		r = $urandom_range(99, 0);
		grow_share = (mix == MIX_GROW) ? 55 : (mix == MIX_SHRINK) ? 20 : 38;
		if (r < 3)
			return 4'($urandom_range(OP_CODE_MAX, OP_CLEAR + 1));
		if (r < 5)
			return OP_CLEAR;
		if (r < 15)
			return OP_CONTAINS;
		if (r < 15 + grow_share)
			return GROW_OPS[$urandom_range(3, 0)];
		return SHRINK_OPS[$urandom_range(4, 0)];
	endfunction

	initial begin
		list_mix_t mix;
		int        sent;
		int        burst;
		bit        drained;

		arst_n    = 1'b0;
		in_valid  = 1'b0;
		operation = OP_PUSH_FRONT;
		key       = '0;
		value     = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty list: pops and searches have nothing to act on
		send_request(OP_POP_FRONT, 0, 0);
		send_request(OP_POP_BACK, 0, 0);
		send_request(OP_CONTAINS, 0, 0);
		send_request(OP_REMOVE_MATCH, 0, 0);
		send_request(OP_REMOVE_AFTER, WORD_MAX, 0);
		// insert into empty list lands at the front
		send_request(OP_INSERT_AFTER, WORD_MIN, WORD_MAX);
		send_request(OP_INSERT_BEFORE, WORD_MAX, WORD_MIN);
		// insert after the tail becomes the new tail
		send_request(OP_INSERT_AFTER, WORD_MAX, 0);
		send_request(OP_PUSH_BACK, 0, -1);
		send_request(OP_PUSH_FRONT, 0, 1);
		// remove before the second entry drops the head
		send_request(OP_REMOVE_BEFORE, WORD_MIN, 0);
		send_request(OP_REMOVE_BEFORE, WORD_MIN, 0);
		send_request(OP_REMOVE_AFTER, -1, 0);
		send_request(OP_CONTAINS, 12345, 0);
		send_request(OP_INSERT_AFTER, 999, 7);
		send_request(OP_REMOVE_MATCH, 0, 0);
		send_request(OP_REMOVE_AFTER, WORD_MIN, 0);
		send_request(4'(OP_CLEAR + 1), WORD_MIN, WORD_MAX);
		send_request(4'(OP_CODE_MAX), -1, -1);
		send_request(OP_CONTAINS, -1, 0);
		send_request(OP_POP_BACK, 0, 0);
		send_request(OP_POP_FRONT, 0, 0);
		// fill to the limit, then every refused push and insert
		repeat (DEPTH) send_request(OP_PUSH_BACK, 0, tracker.pick_value());
		send_request(OP_PUSH_FRONT, 0, 5);
		send_request(OP_PUSH_BACK, 0, 5);
		send_request(OP_INSERT_AFTER, 424242, 5);
		send_request(OP_INSERT_BEFORE, tracker.pick_key(), 5);
		send_request(OP_REMOVE_BEFORE, tracker.held[DEPTH - 1], 0);
		send_request(OP_CLEAR, 0, 0);
		wait_for_replies();

		sent    = 0;
		drained = 0;
		mix     = MIX_GROW;
		while (sent < RANDOM_ITEMS) begin
			if ($urandom_range(2, 0) == 0)
				mix = list_mix_t'($urandom_range(MIX_EVEN, MIX_GROW));
			burst = $urandom_range(24, 1);
			repeat (burst) begin
				send_request(choose_operation(mix), tracker.pick_key(), tracker.pick_value());
				sent++;
			end
			if (!drained && sent >= RANDOM_ITEMS / 2) begin
				wait_for_replies();
				drained = 1;
			end else if ($urandom_range(3, 0) != 0) begin
				idle_cycles($urandom_range(8, 1));
			end
		end

		wait_for_replies();
		repeat (SETTLE) @(posedge clk);
		$display("Summary: %0d requests, %0d replies checked, longest list %0d of %0d",
			tracker.requests, tracker.replies, tracker.peak, DEPTH);
		$display("Summary: %0d refused on a full list, %0d with no entry to act on",
			tracker.refused, tracker.idle_cmds);
		if (tracker.errors == 0 && tracker.pending() == 0)
			$display("ordered_value_list_engine verification clean");
		else
			$display("ordered_value_list_engine verification failed");
		$finish;
	end

endmodule

FILE: sim.f
hw/rtl/ovle_pkg.sv
hw/rtl/ovle_cell.sv
hw/rtl/ovle_ctrl.sv
hw/rtl/ordered_value_list_engine.sv
hw/rtl/ovle_checker.sv
test/testbench.sv
